// File: hdl/gbs_pkg.sv
package gbs_pkg;

  // Query and result fields
  localparam int NUM_W = 20;

  // Bitmap layout: one bit per odd value, 64 odd values (128 integers) per word
  localparam int MAP_WORD_W = 64;
  localparam int MAP_SHIFT  = 7;

  typedef struct packed {
    logic             valid;
    logic             found;
    logic [NUM_W-1:0] smaller;
    logic [NUM_W-1:0] larger;
  } gbs_result_t;

endpackage

// File: hdl/goldbach_split_with_prime_sieve.sv
// Channel  | Ports                                      | Transaction
// ---------+--------------------------------------------+----------------------------------
// query    | start_i, busy_o, number_i                  | at a clock edge with start_i & !busy_o
// result   | done_o, found_o, smaller_prime_o,          | the one cycle done_o is high;
//          | larger_prime_o                             | no back-pressure
//
// After reset the bitmap's ((LIMIT-1)>>7)+1 words (8192 at the default) are cleared one
// word per cycle, then sieved: each odd base i with i*i < LIMIT is tested (S_TEST, S_TCHK),
// and a prime base has its odd multiples from i*i marked. busy_o stays high for all of that.
// A query checks odd candidates until it finds a pair or runs out: odd numbers above 3
// check n-2 only, even ones scan odd p down to 3 from the largest odd value below n/2.
// The receiver cannot stall; busy_o is low while done_o is high, so queries can follow.
module goldbach_split_with_prime_sieve #(
  parameter int LIMIT = 1048576
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [gbs_pkg::NUM_W-1:0] number_i,
  output logic                      done_o,
  output logic                      found_o,
  output logic [gbs_pkg::NUM_W-1:0] smaller_prime_o,
  output logic [gbs_pkg::NUM_W-1:0] larger_prime_o
);
  import gbs_pkg::*;

  // one word covers 128 integers (64 odd values)
  localparam int DEPTH = ((LIMIT - 1) >> MAP_SHIFT) + 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // odd composite bitmap: 1 write port, 2 registered read ports
  logic [MAP_WORD_W-1:0] mem_q [DEPTH];
  logic [MAP_WORD_W-1:0] rdata_a_q, rdata_b_q;

  logic                  sv_ready;
  logic                  sv_we;
  logic [AW-1:0]         sv_waddr;
  logic [MAP_WORD_W-1:0] sv_wdata;
  logic [AW-1:0]         sv_raddr;
  logic [AW-1:0]         q_raddr_a, q_raddr_b;
  logic [AW-1:0]         raddr_a;
  logic                  q_busy;
  logic                  accept;
  gbs_result_t           res;

  gbs_sieve #(
    .LIMIT (LIMIT),
    .AW    (AW)
  ) u_sieve (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rdata_i (rdata_a_q),
    .ready_o (sv_ready),
    .we_o    (sv_we),
    .waddr_o (sv_waddr),
    .wdata_o (sv_wdata),
    .raddr_o (sv_raddr)
  );

  gbs_query #(
    .LIMIT (LIMIT),
    .AW    (AW)
  ) u_query (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept),
    .number_i  (number_i),
    .rdata_a_i (rdata_a_q),
    .rdata_b_i (rdata_b_q),
    .raddr_a_o (q_raddr_a),
    .raddr_b_o (q_raddr_b),
    .busy_o    (q_busy),
    .res_o     (res)
  );

  // port A belongs to the sieve until the bitmap is built
  assign raddr_a = sv_ready ? q_raddr_a : sv_raddr;

  always_ff @(posedge clk_i) begin
    if (sv_we) begin
      mem_q[sv_waddr] <= sv_wdata;
    end
    rdata_a_q <= mem_q[raddr_a];
    rdata_b_q <= mem_q[q_raddr_b];
  end

  assign busy_o          = !sv_ready || q_busy;
  assign accept          = start_i && !busy_o;
  assign done_o          = res.valid;
  assign found_o         = res.found;
  assign smaller_prime_o = res.smaller;
  assign larger_prime_o  = res.larger;

endmodule

// File: hdl/gbs_sieve.sv
module gbs_sieve #(
  parameter int LIMIT = 1048576,
  parameter int AW    = 13
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [gbs_pkg::MAP_WORD_W-1:0] rdata_i,
  output logic                           ready_o,
  output logic                           we_o,
  output logic [AW-1:0]                  waddr_o,
  output logic [gbs_pkg::MAP_WORD_W-1:0] wdata_o,
  output logic [AW-1:0]                  raddr_o
);
  import gbs_pkg::*;

  localparam int DEPTH = ((LIMIT - 1) >> MAP_SHIFT) + 1;
  localparam int VW    = $clog2(LIMIT) + 2;
  localparam logic [VW-1:0] LIMIT_V   = VW'(LIMIT);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_TEST  = 3'd1;
  localparam logic [2:0] S_TCHK  = 3'd2;
  localparam logic [2:0] S_MARK  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [AW-1:0]         addr_q, addr_d;
  logic [VW-1:0]         i_q, i_d;
  logic [VW-1:0]         sq_q, sq_d;
  logic [VW-1:0]         j_q, j_d;
  logic [VW-1:0]         step_q, step_d;
  logic                  pend_q, pend_d;
  logic [AW-1:0]         pend_addr_q, pend_addr_d;
  logic [5:0]            pend_bit_q, pend_bit_d;
  logic                  last_v_q, last_v_d;
  logic [AW-1:0]         last_addr_q;
  logic [MAP_WORD_W-1:0] last_data_q;
  logic [MAP_WORD_W-1:0] base;

  function automatic logic [AW-1:0] word_of(input logic [VW-1:0] v);
    word_of = AW'(v >> MAP_SHIFT);
  endfunction

  // forward the word written last cycle; the memory read missed it
  assign base = (last_v_q && (last_addr_q == pend_addr_q)) ? last_data_q : rdata_i;

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    i_d         = i_q;
    sq_d        = sq_q;
    j_d         = j_q;
    step_d      = step_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    pend_bit_d  = pend_bit_q;
    we_o        = 1'b0;
    waddr_o     = addr_q;
    wdata_o     = '0;
    raddr_o     = word_of(i_q);
    case (state_q)
      S_CLEAR: begin
        we_o = 1'b1;
        if (addr_q == LAST_ADDR) begin
          i_d     = VW'(3);
          sq_d    = VW'(9);
          state_d = S_TEST;
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end
      S_TEST: begin
        if (sq_q >= LIMIT_V) begin
          state_d = S_DONE;
        end else begin
          state_d = S_TCHK;
        end
      end
      S_TCHK: begin
        if (rdata_i[i_q[MAP_SHIFT-1:1]]) begin
          i_d     = i_q + VW'(2);
          sq_d    = sq_q + (i_q << 2) + VW'(4);
          state_d = S_TEST;
        end else begin
          j_d     = sq_q;
          step_d  = i_q << 1;
          state_d = S_MARK;
        end
      end
      S_MARK: begin
        raddr_o = word_of(j_q);
        if (pend_q) begin
          we_o    = 1'b1;
          waddr_o = pend_addr_q;
          wdata_o = base | (MAP_WORD_W'(1) << pend_bit_q);
        end
        if (j_q < LIMIT_V) begin
          pend_d      = 1'b1;
          pend_addr_d = word_of(j_q);
          pend_bit_d  = j_q[MAP_SHIFT-1:1];
          j_d         = j_q + step_q;
        end else begin
          i_d     = i_q + VW'(2);
          sq_d    = sq_q + (i_q << 2) + VW'(4);
          state_d = S_TEST;
        end
      end
      S_DONE: begin
      end
      default: begin
        state_d = S_CLEAR;
        addr_d  = '0;
      end
    endcase
  end

  assign last_v_d = we_o && (state_q == S_MARK);
  assign ready_o  = (state_q == S_DONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      addr_q   <= '0;
      pend_q   <= 1'b0;
      last_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      addr_q   <= addr_d;
      pend_q   <= pend_d;
      last_v_q <= last_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q         <= i_d;
    sq_q        <= sq_d;
    j_q         <= j_d;
    step_q      <= step_d;
    pend_addr_q <= pend_addr_d;
    pend_bit_q  <= pend_bit_d;
    last_addr_q <= waddr_o;
    last_data_q <= wdata_o;
  end

endmodule

// File: hdl/gbs_query.sv
module gbs_query #(
  parameter int LIMIT = 1048576,
  parameter int AW    = 13
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [gbs_pkg::NUM_W-1:0]      number_i,
  input  logic [gbs_pkg::MAP_WORD_W-1:0] rdata_a_i,
  input  logic [gbs_pkg::MAP_WORD_W-1:0] rdata_b_i,
  output logic [AW-1:0]                  raddr_a_o,
  output logic [AW-1:0]                  raddr_b_o,
  output logic                           busy_o,
  output gbs_pkg::gbs_result_t           res_o
);
  import gbs_pkg::*;

  logic             act_q, act_d;
  logic             single_q, single_d;
  logic [NUM_W-1:0] n_q, n_d;
  logic [NUM_W-1:0] p_q, p_d;
  logic             chk_v_q, chk_v_d;
  logic [NUM_W-1:0] chk_p_q, chk_p_d;
  logic [NUM_W-1:0] chk_m_q, chk_m_d;
  gbs_result_t      res_q, res_d;
  logic [NUM_W-1:0] m_now;
  logic [NUM_W-1:0] half;
  logic             issue;
  logic             hit;

  function automatic logic in_map(input logic [NUM_W-1:0] m);
    in_map = (32'(m) < 32'(LIMIT));
  endfunction

  function automatic logic [AW-1:0] word_of(input logic [NUM_W-1:0] m);
    word_of = in_map(m) ? AW'(m >> MAP_SHIFT) : '0;
  endfunction

  function automatic logic is_prime(input logic [NUM_W-1:0] m,
                                    input logic [MAP_WORD_W-1:0] w);
    is_prime = (m >= NUM_W'(3)) && m[0] && in_map(m) && !w[m[MAP_SHIFT-1:1]];
  endfunction

  assign m_now     = n_q - p_q;
  assign half      = number_i >> 1;
  assign issue     = (p_q >= NUM_W'(3));
  assign raddr_a_o = word_of(p_q);
  assign raddr_b_o = word_of(m_now);
  assign hit       = single_q ? is_prime(chk_p_q, rdata_a_i)
                              : (is_prime(chk_p_q, rdata_a_i) && is_prime(chk_m_q, rdata_b_i));

  always_comb begin
    act_d       = act_q;
    single_d    = single_q;
    n_d         = n_q;
    p_d         = p_q;
    chk_v_d     = 1'b0;
    chk_p_d     = p_q;
    chk_m_d     = m_now;
    res_d       = res_q;
    res_d.valid = 1'b0;
    if (!act_q) begin
      if (start_i) begin
        act_d = 1'b1;
        n_d   = number_i;
        if (number_i[0] && (number_i > NUM_W'(3))) begin
          single_d = 1'b1;
          p_d      = number_i - NUM_W'(2);
        end else begin
          single_d = 1'b0;
          if (half > NUM_W'(3)) begin
            p_d = half[0] ? (half - NUM_W'(2)) : (half - NUM_W'(1));
          end else begin
            p_d = NUM_W'(1);
          end
        end
      end
    end else begin
      chk_v_d = issue;
      if (issue) begin
        p_d = single_q ? NUM_W'(1) : (p_q - NUM_W'(2));
      end
      if (chk_v_q && hit) begin
        act_d         = 1'b0;
        chk_v_d       = 1'b0;
        res_d.valid   = 1'b1;
        res_d.found   = 1'b1;
        res_d.smaller = single_q ? NUM_W'(2) : chk_p_q;
        res_d.larger  = single_q ? chk_p_q : chk_m_q;
      end else if (!issue) begin
        act_d         = 1'b0;
        res_d.valid   = 1'b1;
        res_d.found   = 1'b0;
        res_d.smaller = '0;
        res_d.larger  = '0;
      end
    end
  end

  assign busy_o = act_q;
  assign res_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= 1'b0;
      chk_v_q <= 1'b0;
      res_q   <= '0;
    end else begin
      act_q   <= act_d;
      chk_v_q <= chk_v_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    single_q <= single_d;
    n_q      <= n_d;
    p_q      <= p_d;
    chk_p_q  <= chk_p_d;
    chk_m_q  <= chk_m_d;
  end

endmodule

// File: hdl/gbs_checker.sv
module gbs_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start_i,
  input logic                      busy_o,
  input logic                      done_o,
  input logic                      found_o,
  input logic [gbs_pkg::NUM_W-1:0] smaller_prime_o,
  input logic [gbs_pkg::NUM_W-1:0] larger_prime_o
);
  import gbs_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted transaction did not raise busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobed while still busy");

  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !found_o |-> (smaller_prime_o == '0) && (larger_prime_o == '0))
    else $error("not-found result carries nonzero primes");

  a_found_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && found_o |-> (smaller_prime_o < larger_prime_o) && larger_prime_o[0]
                          && (smaller_prime_o[0] || (smaller_prime_o == NUM_W'(2))))
    else $error("found result has bad prime pair");

endmodule

bind goldbach_split_with_prime_sieve gbs_checker u_gbs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .done_o          (done_o),
  .found_o         (found_o),
  .smaller_prime_o (smaller_prime_o),
  .larger_prime_o  (larger_prime_o)
);
